FILE: rtl/dsps_pkg.sv
// Shared types, register indexes and arithmetic helpers for the damped spring point step core.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package dsps_pkg;

   // Field and register types.
   typedef logic signed [31:0] q16_type;
   typedef logic [30:0]        coef_type;
   typedef logic [16:0]        step_type;
   typedef logic [7:0]         colour_type;
   typedef logic [2:0]         csr_index_type;
   typedef logic [15:0]        hue_type;

   // Register indexes of the configuration port.
   localparam csr_index_type CSR_STIFFNESS    = 3'd0;
   localparam csr_index_type CSR_DAMPING      = 3'd1;
   localparam csr_index_type CSR_INVERSE_MASS = 3'd2;
   localparam csr_index_type CSR_REST_X       = 3'd3;
   localparam csr_index_type CSR_REST_Y       = 3'd4;
   localparam csr_index_type CSR_REST_Z       = 3'd5;

   // Reset values of the coefficient registers.
   localparam coef_type STIFFNESS_RESET    = 31'd65536;
   localparam coef_type DAMPING_RESET      = 31'd6554;
   localparam coef_type INVERSE_MASS_RESET = 31'd65536;

   // Saturation limits of Q16.16.
   localparam q16_type Q16_MAX = 32'sh7FFF_FFFF;
   localparam q16_type Q16_MIN = 32'sh8000_0000;

   // Serial multiplier: one multiplier bit per cycle.
   localparam int MUL_BITS = 32;
   localparam int CNT_W    = $clog2(MUL_BITS);

   // Hue: |z| is divided by this constant, then the hue is offset by one half.
   localparam logic [6:0] HUE_DIVISOR = 7'd50;
   localparam hue_type    HUE_BIAS    = 16'h8000;
   localparam hue_type    HUE_OFS_R   = 16'd0;
   localparam hue_type    HUE_OFS_G   = 16'd43691;
   localparam hue_type    HUE_OFS_B   = 16'd21845;

   // Clamp a 33-bit sum to Q16.16.
   function automatic q16_type sat33(input logic signed [32:0] v);
      q16_type r;
      if (v[32] == v[31]) begin
         r = v[31:0];
      end else if (v[32]) begin
         r = Q16_MIN;
      end else begin
         r = Q16_MAX;
      end
      return r;
   endfunction

   // Clamp a 48-bit value to Q16.16.
   function automatic q16_type sat48(input logic signed [47:0] v);
      q16_type r;
      if ((v[47:31] == '0) || (v[47:31] == '1)) begin
         r = v[31:0];
      end else if (v[47]) begin
         r = Q16_MIN;
      end else begin
         r = Q16_MAX;
      end
      return r;
   endfunction

   // One channel of a full-saturation, full-value HSV colour.
   function automatic colour_type hue_channel(input hue_type h, input hue_type ofs);
      hue_type            f;
      logic [18:0]        f6;
      logic signed [19:0] p;
      logic [18:0]        mag;
      logic [16:0]        c;
      logic [24:0]        scaled;
      f   = h + ofs;
      f6  = ({3'b0, f} << 2) + ({3'b0, f} << 1);
      p   = $signed({1'b0, f6}) - 20'sd196608;
      mag = p[19] ? 19'(-p) : p[18:0];
      if (mag <= 19'd65536) begin
         c = 17'd0;
      end else if (mag >= 19'd131072) begin
         c = 17'd65536;
      end else begin
         c = 17'(mag - 19'd65536);
      end
      scaled = ({8'b0, c} << 8) - {8'b0, c} + 25'd32768;
      return scaled[23:16];
   endfunction

endpackage

FILE: rtl/damped_spring_point_step_core.sv
// Damped spring point step core: one point mass on a spring, one Euler step per input word.
// Depends on dsps_pkg for types, register indexes and saturation helpers.
`timescale 1ns / 1ps

// One input word carries the tick length; the block answers it with one result word holding
// the new position and a hue colour taken from |z|. All products go through a single
// bit-serial multiplier that takes one multiplier bit per cycle, each product framed by an
// operand load and a write-back, and a tick needs 19 products plus a serial division of |z|
// by 50 for the hue. The result word is loaded once the output register is free, and the
// next input word is taken only after the whole tick, including the velocity damping that
// follows the result word, is complete; a result still stalled when the next is due holds the tick.
// Configuration writes are always taken (csr_ready is high) and must only be
// made while no tick is in progress.
module damped_spring_point_step_core (
   input  logic                    clock,
   input  logic                    reset,
   // Input channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  dsps_pkg::step_type      req_step_size,
   // Result channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output dsps_pkg::q16_type       rsp_out_x,
   output dsps_pkg::q16_type       rsp_out_y,
   output dsps_pkg::q16_type       rsp_out_z,
   output dsps_pkg::colour_type    rsp_red,
   output dsps_pkg::colour_type    rsp_green,
   output dsps_pkg::colour_type    rsp_blue,
   // Configuration write channel
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  dsps_pkg::csr_index_type csr_index,
   input  dsps_pkg::q16_type       csr_wdata
);
   import dsps_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_POST,
      ST_HUE,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      OP_SPRING,
      OP_DAMP,
      OP_FMUL,
      OP_VEL,
      OP_POS,
      OP_SCALE,
      OP_VSCALE
   } op_type;

   // Control registers
   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   logic [1:0]       axis_ff, axis_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Configuration registers
   coef_type stiff_ff, stiff_in;
   coef_type damp_ff, damp_in;
   coef_type invm_ff, invm_in;
   q16_type  rest_ff [3];
   q16_type  rest_in [3];

   // Point state
   q16_type  pos_ff [3];
   q16_type  pos_in [3];
   q16_type  vel_ff [3];
   q16_type  vel_in [3];
   q16_type  acc_ff [3];
   q16_type  acc_in [3];

   // Working registers
   step_type          dt_ff, dt_in;
   q16_type           tmp_ff, tmp_in;
   q16_type           s_ff, s_in;
   q16_type           mcand_ff, mcand_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [31:0]       absz_ff, absz_in;
   logic [5:0]        rem_ff, rem_in;
   hue_type           quo_ff, quo_in;

   // Result registers
   q16_type    out_x_ff, out_x_in;
   q16_type    out_y_ff, out_y_in;
   q16_type    out_z_ff, out_z_in;
   colour_type red_ff, red_in;
   colour_type green_ff, green_in;
   colour_type blue_ff, blue_in;

   // Combinational helpers
   logic               req_accept;
   logic               mul_last;
   logic signed [32:0] mul_mcand;
   logic signed [32:0] mul_addend;
   logic signed [32:0] mul_sum;
   q16_type            diff;
   q16_type            prod_q;
   logic signed [42:0] prod_q21;
   q16_type            spring;
   logic [6:0]         div_trial;
   hue_type            hue;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_out_x  = out_x_ff;
   assign rsp_out_y  = out_y_ff;
   assign rsp_out_z  = out_z_ff;
   assign rsp_red    = red_ff;
   assign rsp_green  = green_ff;
   assign rsp_blue   = blue_ff;

   // Shift-add step of the signed multiplier; the sign bit of the multiplier subtracts.
   assign mul_last   = (cnt_ff == CNT_W'(MUL_BITS - 1));
   assign mul_mcand  = {mcand_ff[31], mcand_ff};
   assign mul_addend = prod_ff[0] ? (mul_last ? -mul_mcand : mul_mcand) : 33'sd0;
   assign mul_sum    = $signed({prod_ff[63], prod_ff[63:32]}) + mul_addend;

   // Spring displacement of the current axis.
   assign diff = sat33($signed({pos_ff[axis_ff][31], pos_ff[axis_ff]}) -
                       $signed({rest_ff[axis_ff][31], rest_ff[axis_ff]}));

   // Product scaled back to Q16.16, and the negated spring term scaled by 1/32 as well.
   assign prod_q   = sat48(prod_ff[63:16]);
   assign prod_q21 = prod_ff[63:21];
   assign spring   = sat48(-$signed({{5{prod_q21[42]}}, prod_q21}));

   // Restoring division of |z| by a constant, one quotient bit per cycle.
   assign div_trial = {rem_ff, absz_ff[31]};
   assign hue       = quo_ff + HUE_BIAS;

   // Next-state logic of the sequencer and datapath.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      axis_in      = axis_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      stiff_in     = stiff_ff;
      damp_in      = damp_ff;
      invm_in      = invm_ff;
      rest_in      = rest_ff;
      pos_in       = pos_ff;
      vel_in       = vel_ff;
      acc_in       = acc_ff;
      dt_in        = dt_ff;
      tmp_in       = tmp_ff;
      s_in         = s_ff;
      mcand_in     = mcand_ff;
      prod_in      = prod_ff;
      absz_in      = absz_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_z_in     = out_z_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;

      // Register writes; the rest position never moves the point itself.
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_STIFFNESS:    stiff_in   = csr_wdata[30:0];
            CSR_DAMPING:      damp_in    = csr_wdata[30:0];
            CSR_INVERSE_MASS: invm_in    = csr_wdata[30:0];
            CSR_REST_X:       rest_in[0] = csr_wdata;
            CSR_REST_Y:       rest_in[1] = csr_wdata;
            CSR_REST_Z:       rest_in[2] = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               dt_in    = req_step_size;
               op_in    = OP_SPRING;
               axis_in  = 2'd0;
               state_in = ST_LOAD;
            end
         end

         // Select the operands of the next product.
         ST_LOAD: begin
            cnt_in   = '0;
            state_in = ST_MUL;
            unique case (op_ff)
               OP_SPRING: begin
                  prod_in  = {32'b0, diff};
                  mcand_in = {1'b0, stiff_ff};
               end
               OP_DAMP: begin
                  prod_in  = {32'b0, vel_ff[axis_ff]};
                  mcand_in = {1'b0, damp_ff};
               end
               OP_FMUL: begin
                  prod_in  = {32'b0, tmp_ff};
                  mcand_in = {1'b0, invm_ff};
               end
               OP_VEL: begin
                  prod_in  = {32'b0, acc_ff[axis_ff]};
                  mcand_in = {15'b0, dt_ff};
               end
               OP_POS: begin
                  prod_in  = {32'b0, vel_ff[axis_ff]};
                  mcand_in = {15'b0, dt_ff};
               end
               OP_SCALE: begin
                  prod_in  = {32'b0, 15'b0, dt_ff};
                  mcand_in = {1'b0, damp_ff};
               end
               OP_VSCALE: begin
                  prod_in  = {32'b0, vel_ff[axis_ff]};
                  mcand_in = s_ff;
               end
               default: state_in = ST_IDLE;
            endcase
         end

         // One multiplier bit per cycle.
         ST_MUL: begin
            prod_in = {mul_sum, prod_ff[31:1]};
            cnt_in  = cnt_ff + 1'b1;
            if (mul_last) begin
               state_in = ST_POST;
            end
         end

         // Write the product back and pick the next operation.
         ST_POST: begin
            state_in = ST_LOAD;
            unique case (op_ff)
               OP_SPRING: begin
                  tmp_in = spring;
                  op_in  = OP_DAMP;
               end
               OP_DAMP: begin
                  tmp_in = sat33($signed({tmp_ff[31], tmp_ff}) - $signed({prod_q[31], prod_q}));
                  op_in  = OP_FMUL;
               end
               OP_FMUL: begin
                  acc_in[axis_ff] = sat33($signed({acc_ff[axis_ff][31], acc_ff[axis_ff]}) +
                                          $signed({prod_q[31], prod_q}));
                  op_in = OP_VEL;
               end
               OP_VEL: begin
                  vel_in[axis_ff] = sat33($signed({vel_ff[axis_ff][31], vel_ff[axis_ff]}) +
                                          $signed({prod_q[31], prod_q}));
                  op_in = OP_POS;
               end
               OP_POS: begin
                  pos_in[axis_ff] = sat33($signed({pos_ff[axis_ff][31], pos_ff[axis_ff]}) +
                                          $signed({prod_q[31], prod_q}));
                  if (axis_ff == 2'd2) begin
                     state_in = ST_HUE;
                  end else begin
                     axis_in = axis_ff + 1'b1;
                     op_in   = OP_SPRING;
                  end
               end
               OP_SCALE: begin
                  s_in    = prod_q;
                  op_in   = OP_VSCALE;
                  axis_in = 2'd0;
               end
               OP_VSCALE: begin
                  vel_in[axis_ff] = prod_q;
                  if (axis_ff == 2'd2) begin
                     state_in = ST_IDLE;
                  end else begin
                     axis_in = axis_ff + 1'b1;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end

         // Take the magnitude of z for the hue division.
         ST_HUE: begin
            absz_in  = pos_ff[2][31] ? 32'(-pos_ff[2]) : pos_ff[2];
            rem_in   = '0;
            quo_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end

         ST_DIV: begin
            absz_in = {absz_ff[30:0], 1'b0};
            if (div_trial >= HUE_DIVISOR) begin
               rem_in = 6'(div_trial - HUE_DIVISOR);
               quo_in = {quo_ff[14:0], 1'b1};
            end else begin
               rem_in = div_trial[5:0];
               quo_in = {quo_ff[14:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (mul_last) begin
               state_in = ST_EMIT;
            end
         end

         // Load the result word once the output register is free, then damp the velocity.
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_x_in     = pos_ff[0];
               out_y_in     = pos_ff[1];
               out_z_in     = pos_ff[2];
               red_in       = hue_channel(hue, HUE_OFS_R);
               green_in     = hue_channel(hue, HUE_OFS_G);
               blue_in      = hue_channel(hue, HUE_OFS_B);
               rsp_valid_in = 1'b1;
               op_in        = OP_SCALE;
               axis_in      = 2'd0;
               state_in     = ST_LOAD;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // State, configuration, point, working and result registers.
   always_ff @(posedge clock) begin
      dt_ff    <= dt_in;
      tmp_ff   <= tmp_in;
      s_ff     <= s_in;
      mcand_ff <= mcand_in;
      prod_ff  <= prod_in;
      absz_ff  <= absz_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
      out_z_ff <= out_z_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
      cnt_ff   <= cnt_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_SPRING;
         axis_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
         stiff_ff     <= STIFFNESS_RESET;
         damp_ff      <= DAMPING_RESET;
         invm_ff      <= INVERSE_MASS_RESET;
         for (int i = 0; i < 3; i++) begin
            rest_ff[i] <= '0;
            pos_ff[i]  <= '0;
            vel_ff[i]  <= '0;
            acc_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
         stiff_ff     <= stiff_in;
         damp_ff      <= damp_in;
         invm_ff      <= invm_in;
         rest_ff      <= rest_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         acc_ff       <= acc_in;
      end
   end

   // A taken input word always starts the spring product of the x axis.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_LOAD) && (op_ff == OP_SPRING) && (axis_ff == 2'd0))
      else $error("input word did not start the x-axis spring product");

   // Every product and division starts from a cleared bit counter.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_LOAD) || (state_ff == ST_HUE)) |=> (cnt_ff == '0))
      else $error("serial unit started with a stale bit count");

   // The axis counter never leaves the three axes.
   assert property (@(posedge clock) disable iff (reset)
      axis_ff != 2'd3)
      else $error("axis counter out of range");

   // While idle the position does not move, whatever is written to the rest registers.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |=>
         ($stable(pos_ff[0]) && $stable(pos_ff[1]) && $stable(pos_ff[2])))
      else $error("position moved without a tick");

   // A pending result word is never overwritten while it is stalled.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && (state_ff == ST_EMIT)) |=> (state_ff == ST_EMIT))
      else $error("result word overwritten while stalled");

endmodule
